// File: rtl/rmth_pkg.sv
package rmth_pkg;

    // sizing
    localparam int KEY_W      = 32;
    localparam int CAPACITY   = 1024;
    localparam int HEAP_DEPTH = CAPACITY / 2 + 1;
    localparam int SIZE_W     = $clog2(HEAP_DEPTH + 1);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int STATUS_W   = 2;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [SIZE_W-1:0]       t_size;
    typedef logic [CNT_W-1:0]        t_count;

    // action field codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // operation broadcast along a row of cells
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP
    } t_op;

    typedef struct packed {
        t_op  op;
        t_key key;
    } t_cell_cmd;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PLACE,
        S_BAL,
        S_MED,
        S_DONE
    } t_state;

endpackage

// File: rtl/rmth_in_if.sv
interface rmth_in_if;
    logic                valid;
    logic                ready;
    logic                action;
    rmth_pkg::t_key      key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

// File: rtl/rmth_out_if.sv
interface rmth_out_if;
    logic                             valid;
    logic                             ready;
    rmth_pkg::t_key                   value;
    logic [rmth_pkg::STATUS_W-1:0]    status;
    rmth_pkg::t_count                 stored_count;

    modport source (output valid, output value, output status, output stored_count, input ready);
    modport sink   (input valid, input value, input status, input stored_count, output ready);
endinterface

// File: rtl/running_median_two_heaps.sv
// sequence: an insert steps through the place, rebalance and median states, a remove
// through place and median, and a full or empty rejection goes straight to done;
// a new word is taken only in idle, after the last result has left done;
// a stalled output holds the block in done
// reset: synchronous active low, returns to idle and clears the sizes, median and output valid;
// cell contents are not cleared and no clearing pass runs
module running_median_two_heaps (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmth_in_if.sink    i_in,
    rmth_out_if.source o_out
);

    rmth_pkg::t_state    r_state, n_state;
    rmth_pkg::t_size     r_lo_size, n_lo_size;
    rmth_pkg::t_size     r_up_size, n_up_size;
    rmth_pkg::t_key      r_med, n_med;
    rmth_pkg::t_key      r_key;
    logic                r_action;
    rmth_pkg::t_key      r_res_value, n_res_value;
    rmth_pkg::t_status   r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    rmth_pkg::t_key      r_out_value;
    rmth_pkg::t_status   r_out_status;
    rmth_pkg::t_count    r_out_count;

    rmth_pkg::t_cell_cmd w_lo_cmd, w_up_cmd;
    rmth_pkg::t_key      w_lo_root, w_up_root, w_up_min, w_median;
    rmth_pkg::t_count    w_lo_cnt, w_up_cnt, w_total;
    logic                w_accept, w_load, w_slot_free;
    logic                w_full, w_empty, w_lo_more, w_up_more, w_lo_big, w_up_big;
    logic                w_to_upper;
    logic [rmth_pkg::KEY_W:0] w_sum, w_shr, w_half;

    // lower half kept as is, upper half stored inverted so both rows sort descending
    rmth_chain u_lower (
        .i_clk  (i_clk),
        .i_cmd  (w_lo_cmd),
        .i_size (r_lo_size),
        .o_root (w_lo_root)
    );

    rmth_chain u_upper (
        .i_clk  (i_clk),
        .i_cmd  (w_up_cmd),
        .i_size (r_up_size),
        .o_root (w_up_root)
    );

    // size compares
    assign w_lo_cnt  = rmth_pkg::t_count'(r_lo_size);
    assign w_up_cnt  = rmth_pkg::t_count'(r_up_size);
    assign w_total   = w_lo_cnt + w_up_cnt;
    assign w_full    = w_total >= rmth_pkg::t_count'(rmth_pkg::CAPACITY);
    assign w_empty   = (w_total == '0);
    assign w_lo_more = w_lo_cnt > w_up_cnt;
    assign w_up_more = w_up_cnt > w_lo_cnt;
    assign w_lo_big  = w_lo_cnt > (w_up_cnt + rmth_pkg::t_count'(1));
    assign w_up_big  = w_up_cnt > (w_lo_cnt + rmth_pkg::t_count'(1));

    // key above the current median goes to the upper half
    assign w_to_upper = !w_empty && ($signed(r_key) > $signed(r_med));

    // median from the two roots, pair average truncated toward zero
    assign w_up_min = ~w_up_root;
    assign w_sum    = {w_lo_root[rmth_pkg::KEY_W-1], w_lo_root}
                    + {w_up_min[rmth_pkg::KEY_W-1], w_up_min};
    assign w_shr    = {w_sum[rmth_pkg::KEY_W], w_sum[rmth_pkg::KEY_W:1]};
    assign w_half   = w_shr + {{rmth_pkg::KEY_W{1'b0}}, w_sum[rmth_pkg::KEY_W] & w_sum[0]};

    always_comb begin
        if (w_empty) begin
            w_median = '0;
        end else if (w_lo_more) begin
            w_median = w_lo_root;
        end else if (w_up_more) begin
            w_median = w_up_min;
        end else begin
            w_median = w_half[rmth_pkg::KEY_W-1:0];
        end
    end

    // handshake
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_slot_free = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rmth_pkg::S_IDLE: begin
                if (w_accept) begin
                    if ((i_in.action == rmth_pkg::ACT_INSERT && w_full) ||
                        (i_in.action == rmth_pkg::ACT_REMOVE && w_empty)) begin
                        n_state = rmth_pkg::S_DONE;
                    end else begin
                        n_state = rmth_pkg::S_PLACE;
                    end
                end
            end
            rmth_pkg::S_PLACE: begin
                n_state = (r_action == rmth_pkg::ACT_INSERT) ? rmth_pkg::S_BAL
                                                             : rmth_pkg::S_MED;
            end
            rmth_pkg::S_BAL:  n_state = rmth_pkg::S_MED;
            rmth_pkg::S_MED:  n_state = rmth_pkg::S_DONE;
            rmth_pkg::S_DONE: begin
                if (w_slot_free) begin
                    n_state = rmth_pkg::S_IDLE;
                end
            end
            default: n_state = rmth_pkg::S_IDLE;
        endcase
    end

    // controller outputs: ready, row commands, size updates, output load
    always_comb begin
        i_in.ready = 1'b0;
        w_load     = 1'b0;
        w_lo_cmd   = '{op: rmth_pkg::OP_HOLD, key: r_key};
        w_up_cmd   = '{op: rmth_pkg::OP_HOLD, key: ~r_key};
        n_lo_size  = r_lo_size;
        n_up_size  = r_up_size;
        unique case (r_state)
            rmth_pkg::S_IDLE: i_in.ready = 1'b1;
            rmth_pkg::S_PLACE: begin
                if (r_action == rmth_pkg::ACT_INSERT) begin
                    if (w_to_upper) begin
                        w_up_cmd  = '{op: rmth_pkg::OP_PUSH, key: ~r_key};
                        n_up_size = r_up_size + rmth_pkg::t_size'(1);
                    end else begin
                        w_lo_cmd  = '{op: rmth_pkg::OP_PUSH, key: r_key};
                        n_lo_size = r_lo_size + rmth_pkg::t_size'(1);
                    end
                end else if (w_lo_more) begin
                    w_lo_cmd  = '{op: rmth_pkg::OP_POP, key: r_key};
                    n_lo_size = r_lo_size - rmth_pkg::t_size'(1);
                end else begin
                    w_up_cmd  = '{op: rmth_pkg::OP_POP, key: ~r_key};
                    n_up_size = r_up_size - rmth_pkg::t_size'(1);
                end
            end
            rmth_pkg::S_BAL: begin
                if (w_lo_big) begin
                    w_lo_cmd  = '{op: rmth_pkg::OP_POP, key: r_key};
                    w_up_cmd  = '{op: rmth_pkg::OP_PUSH, key: ~w_lo_root};
                    n_lo_size = r_lo_size - rmth_pkg::t_size'(1);
                    n_up_size = r_up_size + rmth_pkg::t_size'(1);
                end else if (w_up_big) begin
                    w_up_cmd  = '{op: rmth_pkg::OP_POP, key: ~r_key};
                    w_lo_cmd  = '{op: rmth_pkg::OP_PUSH, key: w_up_min};
                    n_up_size = r_up_size - rmth_pkg::t_size'(1);
                    n_lo_size = r_lo_size + rmth_pkg::t_size'(1);
                end
            end
            rmth_pkg::S_MED:  ;
            rmth_pkg::S_DONE: w_load = w_slot_free;
            default: ;
        endcase
    end

    // result value, status and median tracking
    always_comb begin
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_med        = r_med;
        if (r_state == rmth_pkg::S_IDLE && w_accept) begin
            n_res_value  = '0;
            n_res_status = rmth_pkg::ST_OK;
            if (i_in.action == rmth_pkg::ACT_INSERT && w_full) begin
                n_res_status = rmth_pkg::ST_FULL;
            end else if (i_in.action == rmth_pkg::ACT_REMOVE && w_empty) begin
                n_res_status = rmth_pkg::ST_EMPTY;
            end
        end else if (r_state == rmth_pkg::S_PLACE && r_action == rmth_pkg::ACT_REMOVE) begin
            n_res_value = w_lo_more ? w_lo_root : w_up_min;
        end else if (r_state == rmth_pkg::S_MED) begin
            n_med = w_median;
            if (r_action == rmth_pkg::ACT_INSERT) begin
                n_res_value = w_median;
            end
        end
    end

    // output register valid
    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmth_pkg::S_IDLE;
            r_lo_size   <= '0;
            r_up_size   <= '0;
            r_med       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lo_size   <= n_lo_size;
            r_up_size   <= n_up_size;
            r_med       <= n_med;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key    <= i_in.key;
            r_action <= i_in.action;
        end
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        if (w_load) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
            r_out_count  <= w_total;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.value        = r_out_value;
    assign o_out.status       = r_out_status;
    assign o_out.stored_count = r_out_count;

    // halves stay balanced between words
    a_balanced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rmth_pkg::S_IDLE) |-> (!w_lo_big && !w_up_big))
        else $error("halves out of balance while idle");

    // never more keys than capacity
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_total <= rmth_pkg::t_count'(rmth_pkg::CAPACITY))
        else $error("stored count above capacity");

    // loaded word carries the count left after the item
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_out_valid && r_out_count == w_total))
        else $error("output count does not match sizes");

endmodule

// File: rtl/rmth_cell.sv
module rmth_cell (
    input  logic                i_clk,
    input  rmth_pkg::t_cell_cmd i_cmd,
    input  logic                i_occ,
    input  rmth_pkg::t_key      i_prev_value,
    input  logic                i_prev_keep,
    input  rmth_pkg::t_key      i_next_value,
    output rmth_pkg::t_key      o_value,
    output logic                o_keep
);

    rmth_pkg::t_key r_value;
    rmth_pkg::t_key n_value;

    // entry stays in place when it ranks at or above the incoming key
    assign o_keep  = i_occ && ($signed(r_value) >= $signed(i_cmd.key));
    assign o_value = r_value;

    // shift right on push past the insertion point, shift left on pop
    always_comb begin
        n_value = r_value;
        unique case (i_cmd.op)
            rmth_pkg::OP_HOLD: n_value = r_value;
            rmth_pkg::OP_PUSH: begin
                if (o_keep) begin
                    n_value = r_value;
                end else if (i_prev_keep) begin
                    n_value = i_cmd.key;
                end else begin
                    n_value = i_prev_value;
                end
            end
            rmth_pkg::OP_POP:  n_value = i_next_value;
            default:           n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// File: rtl/rmth_chain.sv
module rmth_chain (
    input  logic                i_clk,
    input  rmth_pkg::t_cell_cmd i_cmd,
    input  rmth_pkg::t_size     i_size,
    output rmth_pkg::t_key      o_root
);

    rmth_pkg::t_key                  w_value [rmth_pkg::HEAP_DEPTH];
    logic [rmth_pkg::HEAP_DEPTH-1:0] w_keep;

    // sorted row, largest entry in cell zero
    for (genvar g = 0; g < rmth_pkg::HEAP_DEPTH; g++) begin : g_cell
        logic           w_occ;
        logic           w_prev_keep;
        rmth_pkg::t_key w_prev_value;
        rmth_pkg::t_key w_next_value;

        assign w_occ = rmth_pkg::t_size'(g) < i_size;

        if (g == 0) begin : g_head
            assign w_prev_value = i_cmd.key;
            assign w_prev_keep  = 1'b1;
        end else begin : g_body
            assign w_prev_value = w_value[g-1];
            assign w_prev_keep  = w_keep[g-1];
        end

        if (g == rmth_pkg::HEAP_DEPTH - 1) begin : g_tail
            assign w_next_value = w_value[g];
        end else begin : g_link
            assign w_next_value = w_value[g+1];
        end

        rmth_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (i_cmd),
            .i_occ        (w_occ),
            .i_prev_value (w_prev_value),
            .i_prev_keep  (w_prev_keep),
            .i_next_value (w_next_value),
            .o_value      (w_value[g]),
            .o_keep       (w_keep[g])
        );
    end

    assign o_root = w_value[0];

endmodule
